FILE: sv/swsr_pkg.sv
// Shared types and constants for the single-wire sensor reader.
// No dependencies; imported by swsr_core, single_wire_sensor_reader, reader_checker and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package swsr_pkg;

  // Width of the tick counter; the count saturates at its maximum.
  localparam int CNT_W = 16;
  // Compare width wide enough for both the counter and a 16-bit target.
  localparam int LIM_W = (CNT_W > 16) ? CNT_W : 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_BYTE   = 2'd2;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_OK   = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  localparam logic [2:0] REG_START_LOW   = 3'd0;
  localparam logic [2:0] REG_RELEASE     = 3'd1;
  localparam logic [2:0] REG_RESP_SAMPLE = 3'd2;
  localparam logic [2:0] REG_RESP_CONF   = 3'd3;
  localparam logic [2:0] REG_BIT_SAMPLE  = 3'd4;
  localparam logic [2:0] REG_FRAME_BYTES = 3'd5;

  typedef enum logic [8:0] {
    PH_IDLE        = 9'b000000001,
    PH_START_LOW   = 9'b000000010,
    PH_RELEASE     = 9'b000000100,
    PH_RESP_SAMPLE = 9'b000001000,
    PH_RESP_CONF   = 9'b000010000,
    PH_WAIT_LOW    = 9'b000100000,
    PH_BIT_HIGH    = 9'b001000000,
    PH_BIT_DELAY   = 9'b010000000,
    PH_BIT_LOW     = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] tick_count;
    logic [2:0]       bit_index;
    logic [7:0]       shift_byte;
    logic [2:0]       byte_index;
  } swsr_state_t;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_ticks;
    logic [7:0]  response_sample_ticks;
    logic [7:0]  response_confirm_ticks;
    logic [7:0]  bit_sample_ticks;
    logic [3:0]  frame_bytes;
  } swsr_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic [1:0] result_kind;
    logic [1:0] response_status;
    logic [7:0] data_byte;
    logic       last_byte;
  } swsr_result_t;

endpackage

`default_nettype wire

FILE: sv/swsr_core.sv
// Next-state and result logic of the sensor reader for one request.
// Depends on swsr_pkg for the state, configuration and result types.
`timescale 1ns / 1ps
`default_nettype none

module swsr_core import swsr_pkg::*; (
  input  wire swsr_state_t  st,
  input  wire swsr_cfg_t    cfg,
  input  wire logic         func,
  input  wire logic         line_level,
  output swsr_state_t       st_next,
  output swsr_result_t      res
);

  logic [15:0]      target;
  logic [LIM_W-1:0] lim;
  logic [CNT_W-1:0] cnt_inc;
  logic             done;
  logic [CNT_W-1:0] cnt_after;
  logic [3:0]       fb;

  // One shared wait counter serves every timed phase.
  always_comb begin
    unique case (st.phase)
      PH_START_LOW:   target = cfg.start_low_ticks;
      PH_RELEASE:     target = {8'd0, cfg.release_ticks};
      PH_RESP_SAMPLE: target = {8'd0, cfg.response_sample_ticks};
      PH_RESP_CONF:   target = {8'd0, cfg.response_confirm_ticks};
      PH_BIT_DELAY:   target = {8'd0, cfg.bit_sample_ticks};
      default:        target = 16'd0;
    endcase
  end

  always_comb begin
    lim = (target == 16'd0) ? LIM_W'(1) : LIM_W'(target);
    if (lim > LIM_W'(CNT_MAX)) begin
      lim = LIM_W'(CNT_MAX);
    end
    cnt_inc   = (st.tick_count == CNT_MAX) ? st.tick_count : st.tick_count + 1'b1;
    done      = LIM_W'(cnt_inc) >= lim;
    cnt_after = done ? '0 : cnt_inc;
  end

  always_comb begin
    if (cfg.frame_bytes == 4'd0) begin
      fb = 4'd1;
    end else if (cfg.frame_bytes > 4'd8) begin
      fb = 4'd8;
    end else begin
      fb = cfg.frame_bytes;
    end
  end

  always_comb begin
    st_next = st;
    res     = '0;
    if (func == FUNC_START) begin
      // A start request while busy is dropped.
      if (st.phase == PH_IDLE) begin
        st_next.phase      = PH_START_LOW;
        st_next.tick_count = '0;
        st_next.bit_index  = 3'd0;
        st_next.shift_byte = 8'd0;
        st_next.byte_index = 3'd0;
      end
    end else begin
      unique case (st.phase)
        PH_IDLE: begin
        end
        PH_START_LOW: begin
          st_next.tick_count = cnt_after;
          if (done) begin
            st_next.phase = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          st_next.tick_count = cnt_after;
          if (done) begin
            st_next.phase = PH_RESP_SAMPLE;
          end
        end
        PH_RESP_SAMPLE: begin
          st_next.tick_count = cnt_after;
          if (done) begin
            if (!line_level) begin
              st_next.phase = PH_RESP_CONF;
            end else begin
              res.result_kind     = KIND_STATUS;
              res.response_status = STATUS_NONE;
              st_next.phase       = PH_IDLE;
            end
          end
        end
        PH_RESP_CONF: begin
          st_next.tick_count = cnt_after;
          if (done) begin
            res.result_kind = KIND_STATUS;
            if (line_level) begin
              res.response_status = STATUS_OK;
              st_next.phase       = PH_WAIT_LOW;
            end else begin
              res.response_status = STATUS_BAD;
              st_next.phase       = PH_IDLE;
            end
          end
        end
        PH_WAIT_LOW: begin
          if (!line_level) begin
            st_next.phase      = PH_BIT_HIGH;
            st_next.bit_index  = 3'd0;
            st_next.shift_byte = 8'd0;
            st_next.byte_index = 3'd0;
          end
        end
        PH_BIT_HIGH: begin
          if (line_level) begin
            st_next.tick_count = '0;
            st_next.phase      = PH_BIT_DELAY;
          end
        end
        PH_BIT_DELAY: begin
          st_next.tick_count = cnt_after;
          if (done) begin
            st_next.shift_byte = {st.shift_byte[6:0], line_level};
            st_next.bit_index  = st.bit_index + 3'd1;
            st_next.phase      = PH_BIT_LOW;
          end
        end
        PH_BIT_LOW: begin
          if (!line_level) begin
            if (st.bit_index == 3'd0) begin
              res.result_kind = KIND_BYTE;
              res.data_byte   = st.shift_byte;
              if ({1'b0, st.byte_index} + 4'd1 >= fb) begin
                res.last_byte = 1'b1;
                st_next.phase = PH_IDLE;
              end else begin
                st_next.byte_index = st.byte_index + 3'd1;
                st_next.phase      = PH_BIT_HIGH;
              end
              st_next.shift_byte = 8'd0;
            end else begin
              st_next.phase = PH_BIT_HIGH;
            end
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
    res.drive_low = (st_next.phase == PH_START_LOW);
  end

endmodule

`default_nettype wire

FILE: sv/single_wire_sensor_reader.sv
// Top level of the single-wire sensor reader: request register, state, result register.
// Depends on swsr_pkg and swsr_core.
`timescale 1ns / 1ps
`default_nettype none

// Each request is either one microsecond tick with the sampled data line level or a
// start request, and every request yields exactly one result (result_kind tells whether
// it carries a response status, a data byte or nothing). The block takes one request
// per clock cycle; a request passes an input register and then the result register,
// and the only thing that slows the rate is out_ready being low. drive_low in each
// result is the line drive to apply until the next tick. Write configuration registers
// only while no request is in flight.
module single_wire_sensor_reader import swsr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       func,
  input  wire logic       line_level,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            drive_low,
  output logic [1:0]      result_kind,
  output logic [1:0]      response_status,
  output logic [7:0]      data_byte,
  output logic            last_byte,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  swsr_cfg_t    cfg;
  swsr_state_t  st;
  swsr_state_t  st_next;
  swsr_result_t res;
  logic         s1_valid;
  logic         s1_func;
  logic         s1_line;
  logic         s1_go;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks        <= 16'd18000;
      cfg.release_ticks          <= 8'd20;
      cfg.response_sample_ticks  <= 8'd40;
      cfg.response_confirm_ticks <= 8'd80;
      cfg.bit_sample_ticks       <= 8'd40;
      cfg.frame_bytes            <= 4'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_LOW:   cfg.start_low_ticks        <= cfg_data;
        REG_RELEASE:     cfg.release_ticks          <= cfg_data[7:0];
        REG_RESP_SAMPLE: cfg.response_sample_ticks  <= cfg_data[7:0];
        REG_RESP_CONF:   cfg.response_confirm_ticks <= cfg_data[7:0];
        REG_BIT_SAMPLE:  cfg.bit_sample_ticks       <= cfg_data[7:0];
        REG_FRAME_BYTES: cfg.frame_bytes            <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  swsr_core u_core (
    .st         (st),
    .cfg        (cfg),
    .func       (s1_func),
    .line_level (s1_line),
    .st_next    (st_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func <= func;
      s1_line <= line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.tick_count <= '0;
      st.bit_index  <= 3'd0;
      st.shift_byte <= 8'd0;
      st.byte_index <= 3'd0;
      out_valid     <= 1'b0;
    end else begin
      if (s1_go) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      drive_low       <= res.drive_low;
      result_kind     <= res.result_kind;
      response_status <= res.response_status;
      data_byte       <= res.data_byte;
      last_byte       <= res.last_byte;
    end
  end

  // Every path back to idle leaves the wait counter cleared.
  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDLE |-> st.tick_count == '0)
    else $error("tick counter not clear in idle");

  // While the line is pulled low no status or byte can be reported.
  a_drive_no_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_low |-> result_kind == KIND_NONE)
    else $error("result reported during start pulse");

  // Byte fields stay zero unless a byte is reported.
  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_BYTE |-> data_byte == 8'd0 && !last_byte)
    else $error("byte fields set without a byte result");

endmodule

`default_nettype wire

FILE: tb/sv/reader_checker.sv
// Checker for the single-wire sensor reader: tracks the reader state and register
// settings, works out each result and compares it with what the block returns.
// Depends on swsr_pkg.
`timescale 1ns / 1ps

module reader_checker import swsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic        line_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        drive_low,
  input  logic [1:0]  result_kind,
  input  logic [1:0]  response_status,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          in_flight
);

  localparam swsr_cfg_t CFG_AT_RESET = swsr_cfg_t'{16'd18000, 8'd20, 8'd40, 8'd80, 8'd40, 4'd5};

  swsr_cfg_t        rd_cfg = CFG_AT_RESET;
  phase_t           rd_phase = PH_IDLE;
  logic [CNT_W-1:0] rd_ticks = '0;
  logic [2:0]       rd_bit = '0;
  logic [7:0]       rd_shift = '0;
  logic [2:0]       rd_byte = '0;

  swsr_result_t reader_results[$];
  swsr_result_t want;
  swsr_result_t got;
  int mismatches = 0;

  initial begin
    errors = 0;
    in_flight = 0;
  end

  // Counts one tick of a timed wait; true on the tick that ends it.
  function automatic bit wait_elapsed(input logic [15:0] target);
    logic [LIM_W-1:0] lim;
    lim = (target == '0) ? LIM_W'(1) : LIM_W'(target);
    if (lim > LIM_W'(CNT_MAX)) lim = LIM_W'(CNT_MAX);
    if (rd_ticks != CNT_MAX) rd_ticks = rd_ticks + 1'b1;
    if (LIM_W'(rd_ticks) >= lim) begin
      rd_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic swsr_result_t advance_reader(input logic f, input logic lvl);
    swsr_result_t r;
    int unsigned nbytes;
    r = '0;
    nbytes = (rd_cfg.frame_bytes == 0) ? 1 : ((rd_cfg.frame_bytes > 8) ? 8 : rd_cfg.frame_bytes);
    if (f == FUNC_START) begin
      // A start while a read is under way is dropped.
      if (rd_phase == PH_IDLE) begin
        rd_phase = PH_START_LOW;
        rd_ticks = '0;
        rd_bit = '0;
        rd_shift = '0;
        rd_byte = '0;
      end
    end else begin
      unique case (rd_phase)
        PH_IDLE: begin
        end
        PH_START_LOW: begin
          if (wait_elapsed(rd_cfg.start_low_ticks)) rd_phase = PH_RELEASE;
        end
        PH_RELEASE: begin
          if (wait_elapsed(16'(rd_cfg.release_ticks))) rd_phase = PH_RESP_SAMPLE;
        end
        PH_RESP_SAMPLE: begin
          if (wait_elapsed(16'(rd_cfg.response_sample_ticks))) begin
            if (!lvl) begin
              rd_phase = PH_RESP_CONF;
            end else begin
              r.result_kind = KIND_STATUS;
              r.response_status = STATUS_NONE;
              rd_phase = PH_IDLE;
            end
          end
        end
        PH_RESP_CONF: begin
          if (wait_elapsed(16'(rd_cfg.response_confirm_ticks))) begin
            r.result_kind = KIND_STATUS;
            if (lvl) begin
              r.response_status = STATUS_OK;
              rd_phase = PH_WAIT_LOW;
            end else begin
              r.response_status = STATUS_BAD;
              rd_phase = PH_IDLE;
            end
          end
        end
        PH_WAIT_LOW: begin
          if (!lvl) begin
            rd_phase = PH_BIT_HIGH;
            rd_bit = '0;
            rd_shift = '0;
            rd_byte = '0;
          end
        end
        PH_BIT_HIGH: begin
          // The tick that sees the rising edge does not count toward the bit delay.
          if (lvl) begin
            rd_ticks = '0;
            rd_phase = PH_BIT_DELAY;
          end
        end
        PH_BIT_DELAY: begin
          if (wait_elapsed(16'(rd_cfg.bit_sample_ticks))) begin
            rd_shift = {rd_shift[6:0], lvl};
            rd_bit = rd_bit + 3'd1;
            rd_phase = PH_BIT_LOW;
          end
        end
        PH_BIT_LOW: begin
          if (!lvl) begin
            if (rd_bit == '0) begin
              r.result_kind = KIND_BYTE;
              r.data_byte = rd_shift;
              if (int'(rd_byte) + 1 >= nbytes) begin
                r.last_byte = 1'b1;
                rd_phase = PH_IDLE;
              end else begin
                rd_byte = rd_byte + 3'd1;
                rd_phase = PH_BIT_HIGH;
              end
              rd_shift = '0;
            end else begin
              rd_phase = PH_BIT_HIGH;
            end
          end
        end
        default: begin
          rd_phase = PH_IDLE;
        end
      endcase
    end
    r.drive_low = (rd_phase == PH_START_LOW);
    return r;
  endfunction

  function automatic void store_register(input logic [2:0] idx, input logic [15:0] val);
    unique case (idx)
      REG_START_LOW:   rd_cfg.start_low_ticks = val;
      REG_RELEASE:     rd_cfg.release_ticks = val[7:0];
      REG_RESP_SAMPLE: rd_cfg.response_sample_ticks = val[7:0];
      REG_RESP_CONF:   rd_cfg.response_confirm_ticks = val[7:0];
      REG_BIT_SAMPLE:  rd_cfg.bit_sample_ticks = val[7:0];
      REG_FRAME_BYTES: rd_cfg.frame_bytes = val[3:0];
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s differs, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rd_cfg = CFG_AT_RESET;
      rd_phase = PH_IDLE;
      rd_ticks = '0;
      rd_bit = '0;
      rd_shift = '0;
      rd_byte = '0;
      reader_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) store_register(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        got = swsr_result_t'{drive_low, result_kind, response_status, data_byte, last_byte};
        if (reader_results.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %p",
                   $time, got);
          mismatches++;
        end else begin
          want = reader_results.pop_front();
          check_field("drive_low", want.drive_low, got.drive_low);
          check_field("result_kind", want.result_kind, got.result_kind);
          check_field("response_status", want.response_status, got.response_status);
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("last_byte", want.last_byte, got.last_byte);
        end
      end
      if (in_valid && in_ready) reader_results.push_back(advance_reader(func, line_level));
    end
    errors <= mismatches;
    in_flight <= reader_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for single_wire_sensor_reader: drives sensor frames, noise and register
// settings under random stalls, and reports the verdict.
// Depends on swsr_pkg, reader_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import swsr_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 130;
  localparam logic [2:0] REG_PAST_END_0 = 3'd6;
  localparam logic [2:0] REG_PAST_END_1 = 3'd7;

  typedef enum int {FRAME_GOOD, FRAME_SILENT, FRAME_BAD} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_TICK;
  logic        line_level = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        drive_low;
  logic [1:0]  result_kind;
  logic [1:0]  response_status;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_START_LOW;
  logic [15:0] cfg_data = '0;

  int errors;
  int in_flight;

  // Settings the block holds, used to place the sample ticks of each frame.
  swsr_cfg_t setting = swsr_cfg_t'{16'd18000, 8'd20, 8'd40, 8'd80, 8'd40, 4'd5};
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int sent = 0;
  int cycles = 0;

  single_wire_sensor_reader u_top (
    .clk, .rst, .in_valid, .in_ready, .func, .line_level,
    .out_valid, .out_ready, .drive_low, .result_kind, .response_status,
    .data_byte, .last_byte, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  reader_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .func, .line_level,
    .out_valid, .out_ready, .drive_low, .result_kind, .response_status,
    .data_byte, .last_byte, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .in_flight
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_req(input logic f, input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    line_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One tick inside a frame; now and then a start request lands on the busy block first.
  task automatic busy_tick(input logic lvl);
    if ($urandom_range(63) == 0) send_req(FUNC_START, 1'($urandom));
    send_req(FUNC_TICK, lvl);
    sent++;
  endtask

  // Ticks through a timed wait; only the level on its final tick matters.
  task automatic hold_for(input int unsigned target, input logic sample);
    int unsigned n;
    n = (target == 0) ? 1 : target;
    repeat (n - 1) busy_tick(1'($urandom));
    busy_tick(sample);
  endtask

  task automatic read_frame(input frame_kind_t kind, input int pattern);
    int unsigned nbytes;
    logic [7:0] val;
    int i;
    nbytes = (setting.frame_bytes == 0) ? 1 : ((setting.frame_bytes > 8) ? 8 : setting.frame_bytes);
    send_req(FUNC_START, 1'($urandom));
    sent++;
    hold_for(setting.start_low_ticks, 1'($urandom));
    hold_for(setting.release_ticks, 1'($urandom));
    hold_for(setting.response_sample_ticks, kind == FRAME_SILENT);
    if (kind != FRAME_SILENT) begin
      hold_for(setting.response_confirm_ticks, kind == FRAME_GOOD);
      if (kind == FRAME_GOOD) begin
        repeat ($urandom_range(3)) busy_tick(1'b1);
        busy_tick(1'b0);
        repeat (nbytes) begin
          val = (pattern < 0) ? 8'($urandom) : 8'(pattern);
          for (i = 7; i >= 0; i--) begin
            repeat ($urandom_range(2)) busy_tick(1'b0);
            busy_tick(1'b1);
            hold_for(setting.bit_sample_ticks, val[i]);
            repeat ($urandom_range(2)) busy_tick(1'b1);
            busy_tick(1'b0);
          end
        end
      end
    end
  endtask

  // Ticks on an idle block change nothing but still produce a result.
  task automatic line_noise(input int unsigned n);
    repeat (n) send_req(FUNC_TICK, 1'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Unused upper data bits are randomized; the block must drop them.
  task automatic apply_setting(input swsr_cfg_t s);
    write_reg(REG_START_LOW, s.start_low_ticks);
    write_reg(REG_RELEASE, {8'($urandom), s.release_ticks});
    write_reg(REG_RESP_SAMPLE, {8'($urandom), s.response_sample_ticks});
    write_reg(REG_RESP_CONF, {8'($urandom), s.response_confirm_ticks});
    write_reg(REG_BIT_SAMPLE, {8'($urandom), s.bit_sample_ticks});
    write_reg(REG_FRAME_BYTES, {12'($urandom), s.frame_bytes});
    if ($urandom_range(1) == 0)
      write_reg(($urandom_range(1) == 0) ? REG_PAST_END_0 : REG_PAST_END_1, 16'($urandom));
    cfg_valid <= 1'b0;
    setting = s;
  endtask

  function automatic swsr_cfg_t random_setting();
    swsr_cfg_t s;
    s.start_low_ticks = 16'($urandom_range(12));
    s.release_ticks = 8'($urandom_range(6));
    s.response_sample_ticks = 8'($urandom_range(6));
    s.response_confirm_ticks = 8'($urandom_range(6));
    s.bit_sample_ticks = 8'($urandom_range(5));
    s.frame_bytes = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3, 1));
    return s;
  endfunction

  task automatic random_traffic(input int upto);
    frame_kind_t kind;
    int pick;
    while (sent < upto) begin
      drain();
      apply_setting(random_setting());
      repeat ($urandom_range(6, 3)) begin
        if (sent < upto) begin
          if ($urandom_range(1) == 0) line_noise($urandom_range(8, 1));
          pick = $urandom_range(99);
          kind = (pick < 70) ? FRAME_GOOD : ((pick < 85) ? FRAME_SILENT : FRAME_BAD);
          read_frame(kind, -1);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct <= 78;
    // Only the start pulse is shortened; the response waits keep their reset values.
    write_reg(REG_START_LOW, 16'd1);
    cfg_valid <= 1'b0;
    setting.start_low_ticks = 16'd1;
    read_frame(FRAME_BAD, -1);
    drain();
    apply_setting(swsr_cfg_t'{16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0});
    read_frame(FRAME_SILENT, -1);
    read_frame(FRAME_BAD, -1);
    read_frame(FRAME_GOOD, 8'hFF);
    read_frame(FRAME_GOOD, 8'h00);
    random_traffic(sent + PHASE_ITEMS);

    send_idle_pct = 78;
    recv_idle_pct <= 19;
    random_traffic(sent + PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    drain();
    apply_setting(random_setting());
    // Stall the output side long enough for the block to back up into its input.
    hold_asked <= hold_asked + 1;
    read_frame(FRAME_GOOD, -1);
    random_traffic(sent + PHASE_ITEMS);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/swsr_pkg.sv
sv/swsr_core.sv
sv/single_wire_sensor_reader.sv
tb/sv/reader_checker.sv
tb/sv/tb_top.sv
